### rtl/core/power_button_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Power button sequencer: assertion macros
// Shared check macros used by the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef POWER_BUTTON_SEQUENCER_DEFINES_SVH
`define POWER_BUTTON_SEQUENCER_DEFINES_SVH

// same-cycle implication, masked during reset
`define PBS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbs: same-cycle check failed");

// next-cycle implication, masked during reset
`define PBS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbs: next-cycle check failed");

`endif

### rtl/core/pbs_pkg.sv
// ----------------------------------------------------------------------------
// Power button sequencer package
// Shared types, register indexes and reset values.
// ----------------------------------------------------------------------------
package pbs_pkg;

   localparam int CsrDataWidth = 16;
   localparam int CsrIndexWidth = 3;

   // register reset values
   localparam logic [7:0]  PowerOnHoldRst   = 8'd10;
   localparam logic [7:0]  ShutdownHoldRst  = 8'd50;
   localparam logic [7:0]  PrerunWaitRst    = 8'd240;
   localparam logic [9:0]  RailThresholdRst = 10'd950;
   localparam logic [7:0]  SettleWaitRst    = 8'd10;
   localparam logic [7:0]  WakePulseRst     = 8'd10;
   localparam logic [7:0]  ShutPulseRst     = 8'd10;
   localparam logic [15:0] ShutTimeoutRst   = 16'd3000;

   typedef enum logic [1:0] {
      ACT_TICK = 2'd0,
      ACT_STEP = 2'd1,
      ACT_INIT = 2'd2
   } action_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_POWER_ON_HOLD      = 3'd0,
      CSR_SHUTDOWN_HOLD      = 3'd1,
      CSR_PRERUN_WAIT        = 3'd2,
      CSR_RAIL_THRESHOLD     = 3'd3,
      CSR_SUPPLY_SETTLE_WAIT = 3'd4,
      CSR_WAKE_PULSE_LEN     = 3'd5,
      CSR_SHUT_PULSE_LEN     = 3'd6,
      CSR_SHUTDOWN_TIMEOUT   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  power_on_hold;
      logic [7:0]  shutdown_hold;
      logic [7:0]  prerun_wait;
      logic [9:0]  rail_threshold;
      logic [7:0]  supply_settle_wait;
      logic [7:0]  wake_pulse_len;
      logic [7:0]  shut_pulse_len;
      logic [15:0] shutdown_timeout;
   } cfg_type;

   typedef struct packed {
      action_type  action;
      logic        button_pressed;
      logic [9:0]  rail_sample;
      logic        resume_on;
   } req_type;

   typedef struct packed {
      logic [2:0] phase;
      logic       supply_on;
      logic       wake_pin;
      logic       shut_pin;
      logic       save_request;
      logic       save_on;
      logic       sleep_hint;
   } rsp_type;

   function automatic logic [7:0] sat_inc8(input logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
   endfunction

   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

endpackage

### rtl/core/pbs_if.sv
// ----------------------------------------------------------------------------
// Power button sequencer channels
// Valid/ready request and response interfaces.
// ----------------------------------------------------------------------------
interface pbs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic       button_pressed;
   logic [9:0] rail_sample;
   logic       resume_on;

   modport source (output valid, action, button_pressed, rail_sample, resume_on,
                   input ready);
   modport sink   (input valid, action, button_pressed, rail_sample, resume_on,
                   output ready);
endinterface

interface pbs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] phase;
   logic       supply_on;
   logic       wake_pin;
   logic       shut_pin;
   logic       save_request;
   logic       save_on;
   logic       sleep_hint;

   modport source (output valid, phase, supply_on, wake_pin, shut_pin, save_request,
                          save_on, sleep_hint,
                   input ready);
   modport sink   (input valid, phase, supply_on, wake_pin, shut_pin, save_request,
                         save_on, sleep_hint,
                   output ready);
endinterface

### rtl/core/pbs_csr.sv
// ----------------------------------------------------------------------------
// Power button sequencer configuration registers
// Write-only register file, one register per index.
// ----------------------------------------------------------------------------
module pbs_csr
   import pbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_POWER_ON_HOLD:      cfg_in.power_on_hold      = csr_wdata[7:0];
            CSR_SHUTDOWN_HOLD:      cfg_in.shutdown_hold      = csr_wdata[7:0];
            CSR_PRERUN_WAIT:        cfg_in.prerun_wait        = csr_wdata[7:0];
            CSR_RAIL_THRESHOLD:     cfg_in.rail_threshold     = csr_wdata[9:0];
            CSR_SUPPLY_SETTLE_WAIT: cfg_in.supply_settle_wait = csr_wdata[7:0];
            CSR_WAKE_PULSE_LEN:     cfg_in.wake_pulse_len     = csr_wdata[7:0];
            CSR_SHUT_PULSE_LEN:     cfg_in.shut_pulse_len     = csr_wdata[7:0];
            CSR_SHUTDOWN_TIMEOUT:   cfg_in.shutdown_timeout   = csr_wdata[15:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_on_hold      <= PowerOnHoldRst;
         cfg_ff.shutdown_hold      <= ShutdownHoldRst;
         cfg_ff.prerun_wait        <= PrerunWaitRst;
         cfg_ff.rail_threshold     <= RailThresholdRst;
         cfg_ff.supply_settle_wait <= SettleWaitRst;
         cfg_ff.wake_pulse_len     <= WakePulseRst;
         cfg_ff.shut_pulse_len     <= ShutPulseRst;
         cfg_ff.shutdown_timeout   <= ShutTimeoutRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/pbs_core.sv
// ----------------------------------------------------------------------------
// Power button sequencer core
// Timers, hold counter and phase machine; one word per enabled cycle.
// ----------------------------------------------------------------------------
`include "power_button_sequencer_defines.svh"

module pbs_core
   import pbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type rsp
);

   typedef enum logic [2:0] {
      PH_SLEEP      = 3'd0,
      PH_PON_REQ    = 3'd1,
      PH_WAKE       = 3'd2,
      PH_PRERUN     = 3'd3,
      PH_RUNNING    = 3'd4,
      PH_LOSSCHECK  = 3'd5,
      PH_SHUT_START = 3'd6,
      PH_SHUT_REQ   = 3'd7
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        hold_frozen_ff, hold_frozen_in;
   logic [7:0]  hold_count_ff, hold_count_in;
   logic [7:0]  prerun_count_ff, prerun_count_in;
   logic [7:0]  wake_count_ff, wake_count_in;
   logic [7:0]  settle_count_ff, settle_count_in;
   logic [7:0]  shut_count_ff, shut_count_in;
   logic [7:0]  loss_count_ff, loss_count_in;
   logic [15:0] timeout_count_ff, timeout_count_in;
   logic        supply_ff, supply_in;
   logic        wake_ff, wake_in;
   logic        shut_ff, shut_in;
   logic        save_req;
   logic        save_val;
   logic        present;

   assign present = item.rail_sample > cfg.rail_threshold;

   always_comb begin
      phase_in         = phase_ff;
      hold_frozen_in   = hold_frozen_ff;
      hold_count_in    = hold_count_ff;
      prerun_count_in  = prerun_count_ff;
      wake_count_in    = wake_count_ff;
      settle_count_in  = settle_count_ff;
      shut_count_in    = shut_count_ff;
      loss_count_in    = loss_count_ff;
      timeout_count_in = timeout_count_ff;
      supply_in        = supply_ff;
      wake_in          = wake_ff;
      shut_in          = shut_ff;
      save_req         = 1'b0;
      save_val         = 1'b0;

      unique case (item.action)
         ACT_TICK: begin
            // a frozen hold counter is cleared and released by the next tick, button pressed or not
            if (item.button_pressed && !hold_frozen_ff) begin
               hold_count_in = sat_inc8(hold_count_ff);
            end else begin
               hold_frozen_in = 1'b0;
               hold_count_in  = 8'h00;
            end
            prerun_count_in  = sat_inc8(prerun_count_ff);
            wake_count_in    = sat_inc8(wake_count_ff);
            settle_count_in  = sat_inc8(settle_count_ff);
            shut_count_in    = sat_inc8(shut_count_ff);
            loss_count_in    = sat_inc8(loss_count_ff);
            timeout_count_in = sat_inc16(timeout_count_ff);
         end
         ACT_STEP: begin
            unique case (phase_ff)
               PH_SLEEP: begin
                  supply_in = 1'b0;
                  if (hold_count_ff > cfg.power_on_hold) begin
                     phase_in        = PH_PON_REQ;
                     hold_count_in   = 8'h00;
                     hold_frozen_in  = 1'b1;
                     settle_count_in = 8'h00;
                     save_req        = 1'b1;
                     save_val        = 1'b1;
                  end
               end
               PH_PON_REQ: begin
                  supply_in = 1'b1;
                  if (settle_count_ff > cfg.supply_settle_wait) begin
                     if (present) begin
                        prerun_count_in = 8'h00;
                        phase_in        = PH_PRERUN;
                     end else begin
                        wake_in       = 1'b1;
                        phase_in      = PH_WAKE;
                        wake_count_in = 8'h00;
                     end
                  end
               end
               PH_WAKE: begin
                  if (wake_count_ff > cfg.wake_pulse_len) begin
                     prerun_count_in = 8'h00;
                     phase_in        = PH_PRERUN;
                  end
               end
               PH_PRERUN: begin
                  wake_in = 1'b0;
                  if (prerun_count_ff > cfg.prerun_wait) phase_in = PH_RUNNING;
               end
               PH_RUNNING: begin
                  if (hold_count_ff > cfg.shutdown_hold) begin
                     shut_in        = 1'b1;
                     phase_in       = PH_SHUT_START;
                     hold_count_in  = 8'h00;
                     hold_frozen_in = 1'b1;
                     shut_count_in  = 8'h00;
                     save_req       = 1'b1;
                     save_val       = 1'b0;
                  end
                  // rail loss wins the phase, shutdown request still goes out
                  if (!present) begin
                     loss_count_in = 8'h00;
                     phase_in      = PH_LOSSCHECK;
                  end
               end
               PH_LOSSCHECK: begin
                  if (loss_count_ff != 8'h00) begin
                     phase_in      = present ? PH_RUNNING : PH_SLEEP;
                     hold_count_in = 8'h00;
                  end
               end
               PH_SHUT_START: begin
                  if (shut_count_ff > cfg.shut_pulse_len) begin
                     phase_in         = PH_SHUT_REQ;
                     timeout_count_in = 16'h0000;
                  end
               end
               PH_SHUT_REQ: begin
                  shut_in = 1'b0;
                  if (timeout_count_ff > cfg.shutdown_timeout || !present) begin
                     hold_count_in = 8'h00;
                     phase_in      = PH_SLEEP;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
         ACT_INIT: begin
            phase_in         = item.resume_on ? PH_PON_REQ : PH_SLEEP;
            hold_frozen_in   = item.resume_on;
            hold_count_in    = 8'h00;
            prerun_count_in  = 8'h00;
            wake_count_in    = 8'h00;
            settle_count_in  = 8'h00;
            shut_count_in    = 8'h00;
            loss_count_in    = 8'h00;
            timeout_count_in = 16'h0000;
            supply_in        = 1'b0;
            wake_in          = 1'b0;
            shut_in          = 1'b0;
         end
         default: phase_in = phase_ff; // unused code: report status only
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_SLEEP;
         hold_frozen_ff   <= 1'b0;
         hold_count_ff    <= 8'h00;
         prerun_count_ff  <= 8'h00;
         wake_count_ff    <= 8'h00;
         settle_count_ff  <= 8'h00;
         shut_count_ff    <= 8'h00;
         loss_count_ff    <= 8'h00;
         timeout_count_ff <= 16'h0000;
         supply_ff        <= 1'b0;
         wake_ff          <= 1'b0;
         shut_ff          <= 1'b0;
      end else if (en) begin
         phase_ff         <= phase_in;
         hold_frozen_ff   <= hold_frozen_in;
         hold_count_ff    <= hold_count_in;
         prerun_count_ff  <= prerun_count_in;
         wake_count_ff    <= wake_count_in;
         settle_count_ff  <= settle_count_in;
         shut_count_ff    <= shut_count_in;
         loss_count_ff    <= loss_count_in;
         timeout_count_ff <= timeout_count_in;
         supply_ff        <= supply_in;
         wake_ff          <= wake_in;
         shut_ff          <= shut_in;
      end
   end

   // status after this word
   always_comb begin
      rsp.phase        = phase_in;
      rsp.supply_on    = supply_in;
      rsp.wake_pin     = wake_in;
      rsp.shut_pin     = shut_in;
      rsp.save_request = save_req;
      rsp.save_on      = save_val;
      rsp.sleep_hint   = (phase_in == PH_SLEEP) && (hold_count_in == 8'h00);
   end

   `PBS_ASSERT_IMP(a_wake_pin_phase, clock, reset, wake_ff,
                   phase_ff == PH_WAKE || phase_ff == PH_PRERUN)
   `PBS_ASSERT_IMP(a_supply_in_wake, clock, reset,
                   phase_ff == PH_WAKE || phase_ff == PH_PRERUN, supply_ff)
   `PBS_ASSERT_NXT(a_save_on_pon, clock, reset, en && save_req && save_val,
                   phase_ff == PH_PON_REQ && hold_frozen_ff)

endmodule

### rtl/core/power_button_sequencer.sv
// Path: input register, then the core into the result register, which drives rsp_ch.
// Throughput: one word per cycle unless rsp_ch stalls; the phase update is a single
//   pass between the input register and the result register.
// Reset: synchronous, active high; clears the phase machine, timers, pins and both
//   pipeline valids, and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// Power button sequencer top level
// Input register, phase/timer core, result register and config registers.
// ----------------------------------------------------------------------------
`include "power_button_sequencer_defines.svh"

module power_button_sequencer
   import pbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   pbs_req_if.sink                  req_ch,
   pbs_rsp_if.source                rsp_ch
);

   cfg_type cfg;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type core_rsp;

   logic    advance;
   logic    req_take;

   pbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // the held word moves into the result register when that slot is free or draining
   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   // input slot accepts whenever it is empty or being emptied this cycle
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take = req_ch.valid && req_ch.ready;

   pbs_core u_core (
      .clock (clock),
      .reset (reset),
      .en    (advance),
      .item  (in_item_ff),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.action         <= action_type'(req_ch.action);
         in_item_ff.button_pressed <= req_ch.button_pressed;
         in_item_ff.rail_sample    <= req_ch.rail_sample;
         in_item_ff.resume_on      <= req_ch.resume_on;
      end
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.phase        = rsp_ff.phase;
   assign rsp_ch.supply_on    = rsp_ff.supply_on;
   assign rsp_ch.wake_pin     = rsp_ff.wake_pin;
   assign rsp_ch.shut_pin     = rsp_ff.shut_pin;
   assign rsp_ch.save_request = rsp_ff.save_request;
   assign rsp_ch.save_on      = rsp_ff.save_on;
   assign rsp_ch.sleep_hint   = rsp_ff.sleep_hint;

   // a held word that cannot move must block the input side
   `PBS_ASSERT_IMP(a_full_blocks_req, clock, reset, in_valid_ff && !advance,
                   !req_ch.ready)

endmodule

### verif/power_button_sequencer_checker.sv
// ----------------------------------------------------------------------------
// Power button sequencer checker
// Watches the config port and both channels. Keeps its own model of the phase
// machine, timers and pins. Checks every response word field by field.
// ----------------------------------------------------------------------------
module power_button_sequencer_checker
   import pbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   pbs_req_if                       req_ch,
   pbs_rsp_if                       rsp_ch,
   output int                       failures,
   output int                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] PhSleep     = 3'd0;
   localparam logic [2:0] PhPonReq    = 3'd1;
   localparam logic [2:0] PhWake      = 3'd2;
   localparam logic [2:0] PhPrerun    = 3'd3;
   localparam logic [2:0] PhRunning   = 3'd4;
   localparam logic [2:0] PhLossCheck = 3'd5;
   localparam logic [2:0] PhShutStart = 3'd6;
   localparam logic [2:0] PhShutReq   = 3'd7;

   cfg_type     cfg;
   logic [2:0]  phase_q;
   logic        frozen_q;
   logic [7:0]  hold_q;
   logic [7:0]  prerun_q;
   logic [7:0]  wake_q;
   logic [7:0]  settle_q;
   logic [7:0]  shut_q;
   logic [7:0]  loss_q;
   logic [15:0] timeout_q;
   logic        supply_lvl;
   logic        wake_lvl;
   logic        shut_lvl;

   rsp_type     status_due[$];

   function automatic logic [7:0] up8(input logic [7:0] v);
      return (&v) ? v : v + 8'd1;
   endfunction

   function automatic void clear_sequencer();
      phase_q    = PhSleep;
      frozen_q   = 1'b0;
      hold_q     = '0;
      prerun_q   = '0;
      wake_q     = '0;
      settle_q   = '0;
      shut_q     = '0;
      loss_q     = '0;
      timeout_q  = '0;
      supply_lvl = 1'b0;
      wake_lvl   = 1'b0;
      shut_lvl   = 1'b0;
   endfunction

   // one word through the phase machine; returns the status it leaves behind
   function automatic rsp_type sequence_word(input logic [1:0] act, input logic btn,
                                             input logic [9:0] rail, input logic resume);
      logic    present;
      logic    save_req;
      logic    save_val;
      rsp_type r;
      present  = rail > cfg.rail_threshold;
      save_req = 1'b0;
      save_val = 1'b0;
      case (act)
         ACT_TICK: begin
            if (btn && !frozen_q) begin
               hold_q = up8(hold_q);
            end else begin
               frozen_q = 1'b0;
               hold_q   = '0;
            end
            prerun_q  = up8(prerun_q);
            wake_q    = up8(wake_q);
            settle_q  = up8(settle_q);
            shut_q    = up8(shut_q);
            loss_q    = up8(loss_q);
            timeout_q = (&timeout_q) ? timeout_q : timeout_q + 16'd1;
         end
         ACT_STEP: begin
            case (phase_q)
               PhSleep: begin
                  supply_lvl = 1'b0;
                  if (hold_q > cfg.power_on_hold) begin
                     phase_q  = PhPonReq;
                     hold_q   = '0;
                     frozen_q = 1'b1;
                     settle_q = '0;
                     save_req = 1'b1;
                     save_val = 1'b1;
                  end
               end
               PhPonReq: begin
                  supply_lvl = 1'b1;
                  if (settle_q > cfg.supply_settle_wait) begin
                     if (present) begin
                        prerun_q = '0;
                        phase_q  = PhPrerun;
                     end else begin
                        wake_lvl = 1'b1;
                        phase_q  = PhWake;
                        wake_q   = '0;
                     end
                  end
               end
               PhWake: begin
                  if (wake_q > cfg.wake_pulse_len) begin
                     prerun_q = '0;
                     phase_q  = PhPrerun;
                  end
               end
               PhPrerun: begin
                  wake_lvl = 1'b0;
                  if (prerun_q > cfg.prerun_wait) phase_q = PhRunning;
               end
               PhRunning: begin
                  // long press and rail loss together: request first, loss check wins
                  if (hold_q > cfg.shutdown_hold) begin
                     shut_lvl = 1'b1;
                     phase_q  = PhShutStart;
                     hold_q   = '0;
                     frozen_q = 1'b1;
                     shut_q   = '0;
                     save_req = 1'b1;
                     save_val = 1'b0;
                  end
                  if (!present) begin
                     loss_q  = '0;
                     phase_q = PhLossCheck;
                  end
               end
               PhLossCheck: begin
                  if (loss_q >= 8'd1) begin
                     phase_q = present ? PhRunning : PhSleep;
                     hold_q  = '0;
                  end
               end
               PhShutStart: begin
                  if (shut_q > cfg.shut_pulse_len) begin
                     phase_q   = PhShutReq;
                     timeout_q = '0;
                  end
               end
               default: begin
                  shut_lvl = 1'b0;
                  if (timeout_q > cfg.shutdown_timeout || !present) begin
                     hold_q  = '0;
                     phase_q = PhSleep;
                  end
               end
            endcase
         end
         ACT_INIT: begin
            clear_sequencer();
            if (resume) begin
               phase_q  = PhPonReq;
               frozen_q = 1'b1;
            end
         end
         default: ;
      endcase
      r.phase        = phase_q;
      r.supply_on    = supply_lvl;
      r.wake_pin     = wake_lvl;
      r.shut_pin     = shut_lvl;
      r.save_request = save_req;
      r.save_on      = save_val;
      r.sleep_hint   = (phase_q == PhSleep) && (hold_q == 8'd0);
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg.power_on_hold      = PowerOnHoldRst;
         cfg.shutdown_hold      = ShutdownHoldRst;
         cfg.prerun_wait        = PrerunWaitRst;
         cfg.rail_threshold     = RailThresholdRst;
         cfg.supply_settle_wait = SettleWaitRst;
         cfg.wake_pulse_len     = WakePulseRst;
         cfg.shut_pulse_len     = ShutPulseRst;
         cfg.shutdown_timeout   = ShutTimeoutRst;
         clear_sequencer();
         status_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_POWER_ON_HOLD:      cfg.power_on_hold      = csr_wdata[7:0];
               CSR_SHUTDOWN_HOLD:      cfg.shutdown_hold      = csr_wdata[7:0];
               CSR_PRERUN_WAIT:        cfg.prerun_wait        = csr_wdata[7:0];
               CSR_RAIL_THRESHOLD:     cfg.rail_threshold     = csr_wdata[9:0];
               CSR_SUPPLY_SETTLE_WAIT: cfg.supply_settle_wait = csr_wdata[7:0];
               CSR_WAKE_PULSE_LEN:     cfg.wake_pulse_len     = csr_wdata[7:0];
               CSR_SHUT_PULSE_LEN:     cfg.shut_pulse_len     = csr_wdata[7:0];
               default:                cfg.shutdown_timeout   = csr_wdata[15:0];
            endcase
         end
         // response first: it can only belong to an older word
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (status_due.size() == 0) begin
               $error("response word with no request outstanding");
               failures++;
            end else begin
               want = status_due.pop_front();
               check_field("phase", want.phase, rsp_ch.phase);
               check_field("supply_on", want.supply_on, rsp_ch.supply_on);
               check_field("wake_pin", want.wake_pin, rsp_ch.wake_pin);
               check_field("shut_pin", want.shut_pin, rsp_ch.shut_pin);
               check_field("save_request", want.save_request, rsp_ch.save_request);
               check_field("save_on", want.save_on, rsp_ch.save_on);
               check_field("sleep_hint", want.sleep_hint, rsp_ch.sleep_hint);
            end
         end
         if (req_ch.valid && req_ch.ready)
            status_due.push_back(sequence_word(req_ch.action, req_ch.button_pressed,
                                               req_ch.rail_sample, req_ch.resume_on));
      end
      pending = status_due.size();
   end

endmodule

### verif/power_button_sequencer_tb.sv
// ----------------------------------------------------------------------------
// Power button sequencer testbench
// Drives tick/step/init words with bursty valid and a stalling receiver,
// walks several register settings and leaves checking to the checker.
// ----------------------------------------------------------------------------
module power_button_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pbs_pkg::*;

   // action code the block must ignore (reports status, no state change)
   localparam logic [1:0] ActUnused = 2'd3;
   // receiver hold-off long enough to back the block up into its input
   localparam int LongStallCycles = 300;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   int failures;
   int pending;

   pbs_req_if req_ch ();
   pbs_rsp_if rsp_ch ();

   power_button_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   power_button_sequencer_checker chk (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .failures  (failures),
      .pending   (pending)
   );

   always #2 clock = ~clock;

   // request handshake seen at the rising edge; the sender reads it at the next
   // falling edge, so it never races the block's own updates
   logic req_acc = 1'b0;
   always @(posedge clock) begin
      req_acc <= req_ch.valid && req_ch.ready;
   end

   // settings currently loaded; the random generator sizes its runs from them
   cfg_type settings;

   // sender burst bookkeeping
   int unsigned burst_left = 0;

   // button and rail behave like real signals: long runs, not per-word noise
   logic        btn_level = 1'b0;
   int unsigned btn_run   = 0;
   logic        rail_good = 1'b1;

   // long receiver stall: requested by the stimulus, counted by the receiver
   logic stall_go   = 1'b0;
   logic stall_done = 1'b0;

   // ------------------------------------------------------------------------
   // Receiver: ready changes only at falling edges. Mixes full-rate stretches,
   // coin-flip stretches and sparse stretches, plus one long hold-off.
   // ------------------------------------------------------------------------
   initial begin
      int unsigned mode;
      int unsigned mode_left;
      mode      = 0;
      mode_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_go && !stall_done) begin
            rsp_ch.ready = 1'b0;
            repeat (LongStallCycles) @(negedge clock);
            stall_done = 1'b1;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 80);
         end
         mode_left--;
         case (mode)
            0:       rsp_ch.ready = 1'b1;
            1:       rsp_ch.ready = 1'($urandom_range(0, 1));
            default: rsp_ch.ready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Sender: offers one word and returns at the falling edge after it was
   // taken. valid stays high into the next word unless a gap is drawn.
   // ------------------------------------------------------------------------
   task automatic send_word(input logic [1:0] act, input logic btn,
                            input logic [9:0] rail, input logic resume);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         // mostly short bursts, sometimes a long gap-free stretch
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
      req_ch.valid          = 1'b1;
      req_ch.action         = act;
      req_ch.button_pressed = btn;
      req_ch.rail_sample    = rail;
      req_ch.resume_on      = resume;
      do @(negedge clock); while (!req_acc);
   endtask

   // drop valid and wait until every outstanding word has its response,
   // then let the pipe settle
   task automatic wait_idle();
      req_ch.valid = 1'b0;
      burst_left   = 0;
      do @(negedge clock); while (pending != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CsrDataWidth-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
   endtask

   // load all eight registers; junk in the unused upper bits must be dropped
   task automatic apply_settings(input cfg_type s);
      write_csr(CSR_POWER_ON_HOLD,      {8'($urandom), s.power_on_hold});
      write_csr(CSR_SHUTDOWN_HOLD,      {8'($urandom), s.shutdown_hold});
      write_csr(CSR_PRERUN_WAIT,        {8'($urandom), s.prerun_wait});
      write_csr(CSR_RAIL_THRESHOLD,     {6'($urandom), s.rail_threshold});
      write_csr(CSR_SUPPLY_SETTLE_WAIT, {8'($urandom), s.supply_settle_wait});
      write_csr(CSR_WAKE_PULSE_LEN,     {8'($urandom), s.wake_pulse_len});
      write_csr(CSR_SHUT_PULSE_LEN,     {8'($urandom), s.shut_pulse_len});
      write_csr(CSR_SHUTDOWN_TIMEOUT,   s.shutdown_timeout);
      csr_we   = 1'b0;
      settings = s;
   endtask

   // small timers so the random part walks the whole phase machine
   function automatic cfg_type small_settings();
      cfg_type s;
      s.power_on_hold      = 8'($urandom_range(0, 12));
      s.shutdown_hold      = 8'($urandom_range(0, 12));
      s.prerun_wait        = 8'($urandom_range(0, 20));
      s.rail_threshold     = 10'($urandom_range(64, 960));
      s.supply_settle_wait = 8'($urandom_range(0, 12));
      s.wake_pulse_len     = 8'($urandom_range(0, 12));
      s.shut_pulse_len     = 8'($urandom_range(0, 12));
      s.shutdown_timeout   = 16'($urandom_range(0, 40));
      return s;
   endfunction

   // rail sample on the wanted side of the threshold, often right at the edge
   function automatic logic [9:0] rail_value(input logic good);
      int unsigned thr;
      int unsigned sel;
      thr = settings.rail_threshold;
      sel = $urandom_range(0, 7);
      if (good) begin
         if (thr == 1023) return 10'd1023;
         if (sel == 0) return 10'(thr + 1);
         return 10'($urandom_range(thr + 1, 1023));
      end
      if (sel == 0) return 10'(thr);
      return 10'($urandom_range(0, thr));
   endfunction

   // mostly ticks and steps with a coherent button/rail story; a little init
   // and unused-code noise on top
   task automatic random_items(input int count);
      int unsigned hold_span;
      int unsigned r;
      logic [1:0]  act;
      logic        btn;
      logic [9:0]  rail;
      logic        resume;
      hold_span = (settings.power_on_hold > settings.shutdown_hold) ?
                  settings.power_on_hold : settings.shutdown_hold;
      for (int k = 0; k < count; k++) begin
         if (btn_run == 0) begin
            btn_level = !btn_level;
            btn_run   = btn_level ? $urandom_range(1, hold_span + 6) : $urandom_range(1, 16);
         end
         // rail drops are short; good stretches are long
         if (rail_good ? ($urandom_range(0, 39) == 0) : ($urandom_range(0, 5) == 0))
            rail_good = !rail_good;
         r      = $urandom_range(0, 99);
         btn    = btn_level;
         rail   = rail_value(rail_good);
         resume = 1'($urandom_range(0, 1));
         if (r < 55) begin
            act  = ACT_TICK;
            rail = 10'($urandom_range(0, 1023));
            btn_run--;
         end else if (r < 97) begin
            act = ACT_STEP;
            btn = 1'($urandom_range(0, 1));
         end else if (r < 99) begin
            act = ACT_INIT;
         end else begin
            act  = ActUnused;
            rail = 10'($urandom_range(0, 1023));
         end
         send_word(act, btn, rail, resume);
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      cfg_type s;
      req_ch.valid          = 1'b0;
      req_ch.action         = ACT_TICK;
      req_ch.button_pressed = 1'b0;
      req_ch.rail_sample    = '0;
      req_ch.resume_on      = 1'b0;
      settings.power_on_hold      = PowerOnHoldRst;
      settings.shutdown_hold      = ShutdownHoldRst;
      settings.prerun_wait        = PrerunWaitRst;
      settings.rail_threshold     = RailThresholdRst;
      settings.supply_settle_wait = SettleWaitRst;
      settings.wake_pulse_len     = WakePulseRst;
      settings.shut_pulse_len     = ShutPulseRst;
      settings.shutdown_timeout   = ShutTimeoutRst;

      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed walk with zero timers and threshold 500: every phase, both
      // pulse paths, the long-press-plus-rail-loss step, rail and threshold
      // edges, the unused code and both init flavors.
      s = '0;
      s.rail_threshold = 10'd500;
      apply_settings(s);
      send_word(ACT_STEP, 1'b0, 10'd0, 1'b0);      // sleep, hint high
      send_word(ACT_TICK, 1'b1, 10'd0, 1'b0);      // hold 1
      send_word(ACT_STEP, 1'b0, 10'd0, 1'b0);      // power-on request, save on
      send_word(ACT_STEP, 1'b0, 10'd1023, 1'b0);   // supply up, still settling
      send_word(ACT_TICK, 1'b1, 10'd0, 1'b0);      // frozen hold releases
      send_word(ACT_STEP, 1'b0, 10'd0, 1'b0);      // rail absent: wake pulse
      send_word(ACT_TICK, 1'b1, 10'd0, 1'b0);
      send_word(ACT_STEP, 1'b0, 10'd0, 1'b0);      // into prerun
      send_word(ACT_TICK, 1'b1, 10'd0, 1'b0);
      send_word(ACT_STEP, 1'b0, 10'd501, 1'b0);    // wake off, running
      send_word(ACT_STEP, 1'b0, 10'd500, 1'b0);    // long press and rail at threshold
      send_word(ACT_TICK, 1'b0, 10'd0, 1'b0);
      send_word(ACT_STEP, 1'b0, 10'd1023, 1'b0);   // loss check: back to running
      send_word(ACT_TICK, 1'b1, 10'd0, 1'b0);
      send_word(ACT_STEP, 1'b0, 10'd1023, 1'b0);   // shutdown pulse, save off
      send_word(ACT_TICK, 1'b0, 10'd0, 1'b0);
      send_word(ACT_STEP, 1'b0, 10'd1023, 1'b0);   // shutdown request
      send_word(ACT_STEP, 1'b0, 10'd0, 1'b0);      // rail gone: sleep
      send_word(ActUnused, 1'b1, 10'd1023, 1'b1);  // ignored word, all ones
      send_word(ACT_INIT, 1'b1, 10'd1023, 1'b1);   // resume into power-on
      send_word(ACT_INIT, 1'b0, 10'd0, 1'b0);      // plain init

      // small timers; the receiver holds off once early on so the block
      // backs up and stalls its input
      wait_idle();
      apply_settings(small_settings());
      stall_go = 1'b1;
      random_items(400);

      // second small setting, with a full drain in the middle
      wait_idle();
      apply_settings(small_settings());
      random_items(200);
      wait_idle();
      random_items(200);

      // every register at its top value
      wait_idle();
      s.power_on_hold      = 8'hFF;
      s.shutdown_hold      = 8'hFF;
      s.prerun_wait        = 8'hFF;
      s.rail_threshold     = 10'h3FF;
      s.supply_settle_wait = 8'hFF;
      s.wake_pulse_len     = 8'hFF;
      s.shut_pulse_len     = 8'hFF;
      s.shutdown_timeout   = 16'hFFFF;
      apply_settings(s);
      random_items(150);

      // every register at zero
      wait_idle();
      apply_settings('0);
      random_items(200);

      // power-up values, written back explicitly
      wait_idle();
      s.power_on_hold      = PowerOnHoldRst;
      s.shutdown_hold      = ShutdownHoldRst;
      s.prerun_wait        = PrerunWaitRst;
      s.rail_threshold     = RailThresholdRst;
      s.supply_settle_wait = SettleWaitRst;
      s.wake_pulse_len     = WakePulseRst;
      s.shut_pulse_len     = ShutPulseRst;
      s.shutdown_timeout   = ShutTimeoutRst;
      apply_settings(s);
      random_items(300);

      wait_idle();
      apply_settings(small_settings());
      random_items(350);

      // drain, let the pipe settle, then the verdict
      wait_idle();
      repeat (8) @(negedge clock);
      if (pending != 0) $error("%0d response words never arrived", pending);
      if (failures == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
